[rtl/msa_tensor_cell_score_macros.svh]
// ---------------------------------------------------------------------------
// msa_tensor_cell_score_macros.svh
// Assertion shorthands for the tensor cell scorer. Each expands to a labeled
// concurrent assertion clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MSA_TENSOR_CELL_SCORE_MACROS_SVH
`define MSA_TENSOR_CELL_SCORE_MACROS_SVH

// Same-cycle implication
`define MSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/msa_pkg.sv]
// ---------------------------------------------------------------------------
// msa_pkg
// Shared types and constants of the tensor cell scorer: word layouts of the
// item and result channels, register indexes and reset values.
// ---------------------------------------------------------------------------
package msa_pkg;

  // Number of sequences (tensor dimensions) by default
  localparam int unsigned DIMS_DEF = 3;

  // Neighbor lanes: one per nonempty subset of three dimensions
  localparam int unsigned NUM_LANES = 7;

  // Candidate width: 16-bit score plus up to three pair or gap terms of 8 bits
  localparam int unsigned CAND_W = 18;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_CODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL    = 3'd4;

  // Register reset values
  localparam logic signed [7:0] MATCH_RST    = 8'sd3;
  localparam logic signed [7:0] MISMATCH_RST = -8'sd2;
  localparam logic signed [7:0] GAP_RST      = -8'sd6;
  localparam logic        [7:0] GAP_CODE_RST = 8'd45;
  localparam logic              LOCAL_RST    = 1'b0;

  // Input word: residues at the cell and the lower neighbors' scores
  typedef struct packed {
    logic        [7:0]  residue_0;
    logic        [7:0]  residue_1;
    logic        [7:0]  residue_2;
    logic signed [15:0] nbr_score_1;
    logic signed [15:0] nbr_score_2;
    logic signed [15:0] nbr_score_3;
    logic signed [15:0] nbr_score_4;
    logic signed [15:0] nbr_score_5;
    logic signed [15:0] nbr_score_6;
    logic signed [15:0] nbr_score_7;
    logic        [6:0]  neighbor_valid;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic signed [15:0] cell_score;
    logic        [6:0]  predecessor_mask;
    logic               no_neighbor;
  } out_word_t;

endpackage

[rtl/msa_tensor_cell_score.sv]
// ---------------------------------------------------------------------------
// msa_tensor_cell_score
// Scores one cell of a sum-of-pairs alignment tensor: per neighbor lane the
// pair scores of the decremented dimensions, the gap term of the others and
// the neighbor's stored score; reports the maximum and the tied lanes.
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+-----------------------------
//   in_     | input     | in_valid/in_stall  | msa_pkg::in_word_t
//   out_    | output    | out_valid/out_stall| msa_pkg::out_word_t
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index (3b), cfg_data (8b)
//
// One word per cycle while out_stall is low; an accepted word is registered in
// the input register and then in the result register before out_valid rises.
// The input register and the result register form a two-entry
// pipeline, so a word is taken while a finished result waits downstream.
// The lane scoring and the seven-way max tree sit between the two registers.
// Synchronous active-low reset empties the pipeline and loads register
// defaults. cfg_ready is always high.
// ---------------------------------------------------------------------------
module msa_tensor_cell_score #(
  parameter int unsigned DIMS = msa_pkg::DIMS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // item channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  msa_pkg::in_word_t                   in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output msa_pkg::out_word_t                  out_data,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [msa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [7:0]                          cfg_data
);

  import msa_pkg::*;

  localparam int unsigned LANES = (1 << DIMS) - 1;
  localparam logic [NUM_LANES-1:0] LANE_MASK = NUM_LANES'((1 << LANES) - 1);
  localparam logic signed [CAND_W-1:0] CAND_MIN = {1'b1, {(CAND_W-1){1'b0}}};
  localparam logic signed [CAND_W-1:0] SAT_HI   = CAND_W'(32767);
  localparam logic signed [CAND_W-1:0] SAT_LO   = -CAND_W'(32768);

  // Configuration registers
  logic signed [7:0] match_r;
  logic signed [7:0] mismatch_r;
  logic signed [7:0] gap_r;
  logic        [7:0] gap_code_r;
  logic              local_r;

  // Pipeline registers
  logic      s1_valid_r;
  in_word_t  s1_data_r;
  logic      out_valid_r;
  out_word_t out_data_r;
  logic      s1_adv;
  logic      in_acc;

  // Datapath signals
  logic        [7:0]        res       [3];
  logic signed [7:0]        pw        [3][3];
  logic signed [15:0]       nbr       [NUM_LANES];
  logic signed [CAND_W-1:0] cand      [NUM_LANES];
  logic        [NUM_LANES-1:0] lane_on;
  logic signed [CAND_W-1:0] m_a, m_b, m_c, m_d, m_e, best;
  logic        [NUM_LANES-1:0] mask;
  logic                     any_lane;
  logic signed [CAND_W-1:0] score;
  out_word_t                result;

  function automatic logic signed [CAND_W-1:0] max2(
    input logic signed [CAND_W-1:0] a,
    input logic signed [CAND_W-1:0] b
  );
    return (a > b) ? a : b;
  endfunction

  // Configuration writes, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r    <= MATCH_RST;
      mismatch_r <= MISMATCH_RST;
      gap_r      <= GAP_RST;
      gap_code_r <= GAP_CODE_RST;
      local_r    <= LOCAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MATCH:    match_r    <= cfg_data;
        REG_MISMATCH: mismatch_r <= cfg_data;
        REG_GAP:      gap_r      <= cfg_data;
        REG_GAP_CODE: gap_code_r <= cfg_data;
        REG_LOCAL:    local_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake: stage 1 moves on when the result slot is empty or draining
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
    if (s1_adv && s1_valid_r) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Unpack the registered word
  assign res[0] = s1_data_r.residue_0;
  assign res[1] = s1_data_r.residue_1;
  assign res[2] = s1_data_r.residue_2;
  assign nbr[0] = s1_data_r.nbr_score_1;
  assign nbr[1] = s1_data_r.nbr_score_2;
  assign nbr[2] = s1_data_r.nbr_score_3;
  assign nbr[3] = s1_data_r.nbr_score_4;
  assign nbr[4] = s1_data_r.nbr_score_5;
  assign nbr[5] = s1_data_r.nbr_score_6;
  assign nbr[6] = s1_data_r.nbr_score_7;

  // Pair scores; gap test wins over equality
  always_comb begin
    for (int d = 0; d < 3; d++) begin
      for (int e = 0; e < 3; e++) begin
        if (res[d] == gap_code_r || res[e] == gap_code_r) begin
          pw[d][e] = gap_r;
        end else if (res[d] == res[e]) begin
          pw[d][e] = match_r;
        end else begin
          pw[d][e] = mismatch_r;
        end
      end
    end
  end

  // Per-lane candidate: lane k decrements dimension d when bit d of k is set
  for (genvar k = 1; k <= NUM_LANES; k++) begin : g_lane
    logic signed [CAND_W-1:0] acc;

    always_comb begin
      acc = CAND_W'(nbr[k-1]);
      for (int d = 0; d < 3; d++) begin
        if (d < DIMS) begin
          if (((k >> d) & 1) != 0) begin
            for (int e = d + 1; e < 3; e++) begin
              if (e < DIMS && ((k >> e) & 1) != 0) begin
                acc = acc + CAND_W'(pw[d][e]);
              end
            end
          end else begin
            acc = acc + CAND_W'(gap_r);
          end
        end
      end
    end

    assign lane_on[k-1] = LANE_MASK[k-1] && s1_data_r.neighbor_valid[k-1];
    assign cand[k-1]    = lane_on[k-1] ? acc : CAND_MIN;
  end

  // Seven-way max tree; absent lanes sit below any real candidate
  assign m_a  = max2(cand[0], cand[1]);
  assign m_b  = max2(cand[2], cand[3]);
  assign m_c  = max2(cand[4], cand[5]);
  assign m_d  = max2(m_a, m_b);
  assign m_e  = max2(m_c, cand[6]);
  assign best = max2(m_d, m_e);

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      mask[k] = lane_on[k] && (cand[k] == best);
    end
  end

  assign any_lane = |lane_on;

  // Local clamp, then saturate to 16 bits
  always_comb begin
    score = best;
    if (local_r && score < 0) begin
      score = '0;
    end
    if (score > SAT_HI) begin
      score = SAT_HI;
    end else if (score < SAT_LO) begin
      score = SAT_LO;
    end
    if (any_lane) begin
      result.cell_score       = score[15:0];
      result.predecessor_mask = mask;
      result.no_neighbor      = 1'b0;
    end else begin
      result.cell_score       = '0;
      result.predecessor_mask = '0;
      result.no_neighbor      = 1'b1;
    end
  end

  // Checks
  `include "msa_tensor_cell_score_macros.svh"

  `MSA_ASSERT_NOW(a_empty_cell, out_valid_r && out_data_r.no_neighbor, out_data_r.cell_score == 16'sd0 && out_data_r.predecessor_mask == '0, "empty cell must score zero with no predecessor")
  `MSA_ASSERT_NOW(a_has_pred, out_valid_r && !out_data_r.no_neighbor, out_data_r.predecessor_mask != '0, "scored cell must have a predecessor")
  `MSA_ASSERT_NOW(a_lane_range, out_valid_r, (out_data_r.predecessor_mask & ~LANE_MASK) == '0, "predecessor outside the lanes of this dimension count")
  `MSA_ASSERT_NOW(a_local_pos, out_valid_r && local_r, out_data_r.cell_score >= 0, "local mode result below zero")
  `MSA_ASSERT_NEXT(a_full_hold, s1_valid_r && out_valid_r && out_stall && !in_acc, s1_valid_r && out_valid_r, "pipeline dropped a word while stalled")

endmodule
